@@ src/mcbd_pkg.sv @@
// package for the multi-channel byte deframer
// holds sizes, codes, register reset values and the event type; no dependencies
package mcbd_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int CHANNELS    = 4;
    localparam int NUM_REGS    = 4;

    localparam int BYTE_W    = 8;
    localparam int PAT_W     = 24;
    localparam int CH_W      = 2;
    localparam int KIND_W    = 2;
    localparam int POS_W     = 6;
    localparam int PHASE_W   = 2;
    localparam int CNT_W     = $clog2(MAX_PAYLOAD + 1);
    localparam int CFG_IDX_W = 3;
    localparam int REG_SEL_W = $clog2(NUM_REGS);

    localparam logic [PHASE_W-1:0] PH_HUNT = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HDR2 = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DATA = 2'd2;

    localparam logic [KIND_W-1:0] EVT_BYTE  = 2'd0;
    localparam logic [KIND_W-1:0] EVT_FRAME = 2'd1;
    localparam logic [KIND_W-1:0] EVT_DROP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CHAN0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CHAN3 = 3'd3;

    localparam logic [PAT_W-1:0] PAT_RESET [NUM_REGS] = '{
        24'h550200, 24'h1001FF, 24'h1002FF, 24'h0203FF
    };

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
    } t_evt;

endpackage

@@ src/mcbd_if.sv @@
// channel interfaces of the deframer: received bytes, events, register writes
// depends on mcbd_pkg
interface mcbd_byte_if import mcbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface mcbd_evt_if import mcbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CH_W-1:0]   channel;
    logic [KIND_W-1:0] event_kind;
    logic [POS_W-1:0]  position_or_length;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_event;
    modport source (output valid, output channel, output event_kind,
                    output position_or_length, output payload_byte,
                    output last_event, input ready);
    modport sink   (input valid, input channel, input event_kind,
                    input position_or_length, input payload_byte,
                    input last_event, output ready);
endinterface

interface mcbd_cfg_if import mcbd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [PAT_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/mcbd_cfg_regs.sv @@
// pattern registers, one per channel, written through the config channel
// depends on mcbd_pkg and mcbd_if
module mcbd_cfg_regs import mcbd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mcbd_cfg_if.sink         i_cfg,
    output logic [PAT_W-1:0] o_pat [NUM_REGS]
);

    logic [PAT_W-1:0] r_pat [NUM_REGS];

    assign i_cfg.ready = 1'b1;
    assign o_pat       = r_pat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat <= PAT_RESET;
        end else if (i_cfg.valid && (i_cfg.index < CFG_IDX_W'(NUM_REGS))) begin
            r_pat[i_cfg.index[REG_SEL_W-1:0]] <= i_cfg.data;
        end
    end

endmodule

@@ src/mcbd_chan.sv @@
// one deframer channel: header hunt, payload count and event generation
// depends on mcbd_pkg
module mcbd_chan import mcbd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic [PAT_W-1:0]  i_pat,
    output t_evt              o_evt
);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [BYTE_W-1:0]  h1, h2, tl;

    assign h1 = i_pat[23:16];
    assign h2 = i_pat[15:8];
    assign tl = i_pat[7:0];

    always_comb begin
        o_evt   = '0;
        n_phase = r_phase;
        n_cnt   = r_cnt;
        case (r_phase)
            PH_HDR2: begin
                n_phase = (i_byte == h2) ? PH_DATA : PH_HUNT;
            end
            PH_DATA: begin
                o_evt.valid = 1'b1;
                if (i_byte == tl) begin
                    o_evt.kind = EVT_FRAME;
                    o_evt.pos  = POS_W'(r_cnt);
                    n_cnt      = '0;
                    n_phase    = PH_HUNT;
                end else if (r_cnt < CNT_W'(MAX_PAYLOAD)) begin
                    o_evt.kind = EVT_BYTE;
                    o_evt.pos  = POS_W'(r_cnt);
                    o_evt.data = i_byte;
                    n_cnt      = r_cnt + 1'b1;
                end else begin
                    o_evt.kind = EVT_DROP;
                    o_evt.pos  = POS_W'(MAX_PAYLOAD);
                    o_evt.data = i_byte;
                end
            end
            default: begin
                n_phase = (i_byte == h1) ? PH_HDR2 : PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_cnt   <= '0;
        end else if (i_adv) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ src/mcbd_evt_queue.sv @@
// holds the event set of one byte and sends its events out one per cycle while o_evt is ready,
// lowest channel first, through the output register; depends on mcbd_pkg, mcbd_if
module mcbd_evt_queue import mcbd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  t_evt [CHANNELS-1:0] i_evts,
    output logic                o_take,
    mcbd_evt_if.source          o_evt
);

    logic [CHANNELS-1:0] r_mask, n_mask, pick_oh, rem;
    t_evt                r_slot [CHANNELS];
    logic [CH_W-1:0]     pick_idx;
    logic                out_free, out_load, set_free;

    logic              r_out_valid;
    logic [CH_W-1:0]   r_out_ch;
    logic [KIND_W-1:0] r_out_kind;
    logic [POS_W-1:0]  r_out_pos;
    logic [BYTE_W-1:0] r_out_data;
    logic              r_out_last;

    assign pick_oh = r_mask & (~r_mask + 1'b1);
    assign rem     = r_mask & ~pick_oh;

    always_comb begin
        pick_idx = '0;
        for (int c = CHANNELS - 1; c >= 0; c--) begin
            if (r_mask[c]) begin
                pick_idx = CH_W'(c);
            end
        end
    end

    assign out_free = !r_out_valid || o_evt.ready;
    assign out_load = (|r_mask) && out_free;
    assign set_free = (r_mask == '0) || (out_load && (rem == '0));
    assign o_take   = i_in_valid && set_free;

    always_comb begin
        n_mask = r_mask;
        if (out_load) begin
            n_mask = rem;
        end
        if (o_take) begin
            for (int c = 0; c < CHANNELS; c++) begin
                n_mask[c] = i_evts[c].valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_evt.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_slot[c] <= i_evts[c];
            end
        end
        if (out_load) begin
            r_out_ch   <= pick_idx;
            r_out_kind <= r_slot[pick_idx].kind;
            r_out_pos  <= r_slot[pick_idx].pos;
            r_out_data <= r_slot[pick_idx].data;
            r_out_last <= (rem == '0);
        end
    end

    assign o_evt.valid              = r_out_valid;
    assign o_evt.channel            = r_out_ch;
    assign o_evt.event_kind         = r_out_kind;
    assign o_evt.position_or_length = r_out_pos;
    assign o_evt.payload_byte       = r_out_data;
    assign o_evt.last_event         = r_out_last;

    // events of one byte leave in ascending channel order with no gap
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && o_evt.ready && !r_out_last)
            |=> (r_out_valid && (r_out_ch > $past(r_out_ch))))
        else $error("event order broken");

    a_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == EVT_FRAME)) |-> (r_out_data == '0))
        else $error("frame event carries data");

    a_drop_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_kind == EVT_DROP)) |-> (r_out_pos == POS_W'(MAX_PAYLOAD)))
        else $error("drop event without saturated count");

endmodule

@@ src/multi_channel_byte_deframer.sv @@
// top level of the multi-channel byte deframer
// depends on mcbd_pkg, mcbd_if, mcbd_cfg_regs, mcbd_chan, mcbd_evt_queue
//
// i_rx carries one received byte per item; four channels watch every byte for
// their own first header, second header and tail, set through i_cfg (index 0
// to 3, 24 bits: first header, second header, tail high to low; other indexes
// are ignored). o_evt carries one event per item: channel, kind (payload byte,
// frame complete, byte dropped past the payload limit), position or length,
// the byte, and a flag on the last event of a byte.
// a byte is held in the input register, its event set is formed from it and
// held in the event slots, and its events then move one at a time into the
// output register.
// throughput: one byte per cycle while each byte raises at most one event and
// o_evt does not stall; a byte raising more than one event holds the event set
// until the single output register has drained them, one event per cycle while o_evt is ready.
// reset clears all channels to hunting with zero count and loads the default
// patterns. when o_evt stalls, events wait in the output register and the
// event set, and i_rx.ready drops once the input register also holds a byte.
module multi_channel_byte_deframer import mcbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcbd_byte_if.sink   i_rx,
    mcbd_evt_if.source  o_evt,
    mcbd_cfg_if.sink    i_cfg
);

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                take;
    logic [PAT_W-1:0]    pat [NUM_REGS];
    t_evt [CHANNELS-1:0] evts;

    assign i_rx.ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.valid && i_rx.ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.valid && i_rx.ready) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    mcbd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_pat   (pat)
    );

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        mcbd_chan u_chan (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (take),
            .i_byte  (r_in_byte),
            .i_pat   (pat[c]),
            .o_evt   (evts[c])
        );
    end

    mcbd_evt_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (r_in_valid),
        .i_evts     (evts),
        .o_take     (take),
        .o_evt      (o_evt)
    );

endmodule

@@ tb/tb_multi_channel_byte_deframer.sv @@
`timescale 1ns / 1ps
// testbench for multi_channel_byte_deframer: directed and random byte streams under
// several pattern settings, every event checked against an in-bench deframer predictor
// depends on mcbd_pkg, the mcbd interfaces and the deframer rtl
module tb_multi_channel_byte_deframer;
    import mcbd_pkg::*;

    localparam int IDLE_CYCLES = 12;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(NUM_REGS);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    // default patterns: ch0 55 02 / 00, ch1 10 01 / ff, ch2 10 02 / ff, ch3 02 03 / ff
    localparam logic [BYTE_W-1:0] OPENING [22] = '{
        8'h00, 8'h55, 8'h02, 8'h03, 8'hFF, 8'h00, 8'h10, 8'h01,
        8'h10, 8'h02, 8'h03, 8'h55, 8'h02, 8'hAA, 8'hFF, 8'h00,
        8'h55, 8'h55, 8'h02, 8'h00, 8'hFF, 8'h7E
    };

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_event;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    mcbd_byte_if rx_if ();
    mcbd_evt_if  evt_if ();
    mcbd_cfg_if  cfg_if ();

    multi_channel_byte_deframer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .o_evt   (evt_if),
        .i_cfg   (cfg_if)
    );

    logic [PAT_W-1:0]   chan_pat   [NUM_REGS];
    logic [PHASE_W-1:0] chan_phase [NUM_REGS];
    logic [CNT_W-1:0]   chan_count [NUM_REGS];

    logic [BYTE_W-1:0] byte_q [$];
    t_event            event_q [$];
    t_event            got_ev;
    t_event            want_ev;
    int                errors     = 0;
    bit                rx_taken   = 1'b0;
    bit                calm       = 1'b0;
    int                rx_gap     = 0;
    int                stall_left = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic string show_event(input t_event e);
        return $sformatf("ch=%0d kind=%0d pos=%0d byte=%02h last=%0d",
                         e.channel, e.kind, e.pos, e.data, e.last);
    endfunction

    task automatic report(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        t_event            evs [$];
        t_event            ev;
        logic [BYTE_W-1:0] h1;
        logic [BYTE_W-1:0] h2;
        logic [BYTE_W-1:0] tl;
        for (int c = 0; c < CHANNELS; c++) begin
            h1 = chan_pat[c][23:16];
            h2 = chan_pat[c][15:8];
            tl = chan_pat[c][7:0];
            ev = '0;
            ev.channel = c[CH_W-1:0];
            case (chan_phase[c])
                PH_HDR2: begin
                    chan_phase[c] = (b == h2) ? PH_DATA : PH_HUNT;
                end
                PH_DATA: begin
                    if (b == tl) begin
                        ev.kind = EVT_FRAME;
                        ev.pos  = POS_W'(chan_count[c]);
                        evs.push_back(ev);
                        chan_count[c] = '0;
                        chan_phase[c] = PH_HUNT;
                    end else if (chan_count[c] < MAX_PAYLOAD) begin
                        ev.kind = EVT_BYTE;
                        ev.pos  = POS_W'(chan_count[c]);
                        ev.data = b;
                        evs.push_back(ev);
                        chan_count[c] = chan_count[c] + 1'b1;
                    end else begin
                        ev.kind = EVT_DROP;
                        ev.pos  = POS_W'(MAX_PAYLOAD);
                        ev.data = b;
                        evs.push_back(ev);
                    end
                end
                default: begin
                    chan_phase[c] = (b == h1) ? PH_HDR2 : PH_HUNT;
                end
            endcase
        end
        if (evs.size() > 0) evs[evs.size() - 1].last = 1'b1;
        foreach (evs[i]) event_q.push_back(evs[i]);
    endfunction

    // mostly random, sometimes a byte of some channel's pattern
    function automatic logic [BYTE_W-1:0] pick_byte();
        logic [PAT_W-1:0] p;
        if ($urandom_range(0, 3) != 0) return BYTE_W'($urandom_range(0, 255));
        p = chan_pat[$urandom_range(0, CHANNELS - 1)];
        case ($urandom_range(0, 2))
            0:       return p[23:16];
            1:       return p[15:8];
            default: return p[7:0];
        endcase
    endfunction

    task automatic add_traffic(input int n);
        int               made;
        int               len;
        int               r;
        logic [PAT_W-1:0] p;
        made = 0;
        while (made < n) begin
            p = chan_pat[$urandom_range(0, CHANNELS - 1)];
            r = $urandom_range(0, 99);
            if (r < 70) begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(28, 40)
                                                  : $urandom_range(0, 8);
                byte_q.push_back(p[23:16]);
                byte_q.push_back(p[15:8]);
                for (int i = 0; i < len; i++) byte_q.push_back(pick_byte());
                byte_q.push_back(p[7:0]);
                made += len + 3;
            end else if (r < 85) begin
                // broken header: repeated first header or a wrong second one
                byte_q.push_back(p[23:16]);
                byte_q.push_back(($urandom_range(0, 1) == 0) ? p[23:16] : pick_byte());
                byte_q.push_back(pick_byte());
                made += 3;
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++)
                    byte_q.push_back(BYTE_W'($urandom_range(0, 255)));
                made += len;
            end
        end
    endtask

    task automatic wait_idle();
        while (byte_q.size() != 0 || rx_if.valid || event_q.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] val);
        @(negedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (idx < NUM_REGS) chan_pat[idx[REG_SEL_W-1:0]] = val;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // acceptance of a byte feeds the predictor
    always @(posedge i_clk) begin
        if (i_rst_n && rx_if.valid && rx_if.ready) begin
            rx_taken = 1'b1;
            deframe_byte(rx_if.rx_byte);
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_if.valid <= 1'b0;
        end else if (!rx_if.valid || rx_taken) begin
            if (rx_gap > 0) begin
                rx_if.valid <= 1'b0;
                rx_gap--;
            end else if (byte_q.size() != 0) begin
                rx_if.valid   <= 1'b1;
                rx_if.rx_byte <= byte_q.pop_front();
                rx_gap = calm ? 0 : idle_len();
            end else begin
                rx_if.valid <= 1'b0;
            end
        end
        rx_taken = 1'b0;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            evt_if.ready <= 1'b0;
        end else if (calm) begin
            evt_if.ready <= 1'b1;
        end else if (stall_left > 0) begin
            evt_if.ready <= 1'b0;
            stall_left--;
        end else begin
            evt_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = idle_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && evt_if.valid && evt_if.ready) begin
            got_ev = {evt_if.channel, evt_if.event_kind, evt_if.position_or_length,
                      evt_if.payload_byte, evt_if.last_event};
            if (event_q.size() == 0) begin
                report({"event with none expected: ", show_event(got_ev)});
            end else begin
                want_ev = event_q.pop_front();
                if (got_ev !== want_ev)
                    report({"got ", show_event(got_ev), " want ", show_event(want_ev)});
            end
        end
    end

    initial begin
        cfg_if.valid  = 1'b0;
        cfg_if.index  = '0;
        cfg_if.data   = '0;
        for (int c = 0; c < NUM_REGS; c++) begin
            chan_pat[c]   = PAT_RESET[c];
            chan_phase[c] = PH_HUNT;
            chan_count[c] = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (OPENING[i]) byte_q.push_back(OPENING[i]);
        add_traffic(80);
        wait_idle();

        // random patterns, spare indexes, no idling on either side
        write_reg(REG_CHAN0, PAT_W'($urandom));
        write_reg(REG_CHAN1, PAT_W'($urandom));
        write_reg(REG_CHAN2, PAT_W'($urandom));
        write_reg(REG_CHAN3, PAT_W'($urandom));
        write_reg(REG_SPARE_LO, PAT_W'($urandom));
        write_reg(REG_SPARE_HI, PAT_W'($urandom));
        calm = 1'b1;
        add_traffic(70);
        wait_idle();
        calm = 1'b0;

        // all zero, all ones, tail equal to first header, tail equal to second header
        write_reg(REG_CHAN0, '0);
        write_reg(REG_CHAN1, '1);
        write_reg(REG_CHAN2, 24'hABCDAB);
        write_reg(REG_CHAN3, 24'h3C5A5A);
        add_traffic(80);
        wait_idle();

        write_reg(REG_CHAN0, PAT_RESET[0]);
        write_reg(REG_CHAN1, PAT_RESET[1]);
        write_reg(REG_CHAN2, PAT_RESET[2]);
        write_reg(REG_CHAN3, PAT_W'($urandom));
        add_traffic(70);
        wait_idle();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
